FILE: rtl/dssd_pkg.sv
`timescale 1ns / 1ps
package dssd_pkg;

   localparam int unsigned HeaderBytes = 16;
   localparam logic [21:0] RateDefault = 22'd8000;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_END    = 2'd2,
      KIND_SHORT  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_HEADER,
      OP_SHORT,
      OP_ONE_SAMPLE,
      OP_TWO_SAMPLES,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        with_end;
      logic [7:0]  sample0;
      logic [7:0]  sample1;
      logic        comp;
      logic        looped;
      logic [21:0] rate;
      logic [31:0] loop_start;
      logic [31:0] total;
   } job_type;

   function automatic logic [7:0] delta_of(input logic [3:0] code);
      logic [7:0] d;
      case (code)
         4'h0:    d = 8'h00;
         4'h1:    d = 8'h01;
         4'h2:    d = 8'h04;
         4'h3:    d = 8'h09;
         4'h4:    d = 8'h10;
         4'h5:    d = 8'h19;
         4'h6:    d = 8'h24;
         4'h7:    d = 8'h31;
         4'h8:    d = 8'hC0;
         4'h9:    d = 8'hCF;
         4'hA:    d = 8'hDC;
         4'hB:    d = 8'hE7;
         4'hC:    d = 8'hF0;
         4'hD:    d = 8'hF7;
         4'hE:    d = 8'hFC;
         default: d = 8'hFF;
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/dssd_front.sv
`timescale 1ns / 1ps
module dssd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             final_byte,
   output logic             push,
   output dssd_pkg::job_type job
);

   logic [4:0]  pos_ff, pos_in;
   logic [31:0] word_ff, word_in;
   logic        comp_ff, comp_in;
   logic        loop_ff, loop_in;
   logic [21:0] rate_ff, rate_in;
   logic [31:0] loff_ff, loff_in;
   logic [31:0] limit_ff, limit_in;
   logic [7:0]  level_ff, level_in;
   logic [31:0] count_ff, count_in;

   logic [31:0] word_new;
   logic [21:0] rate_raw;
   logic [7:0]  level_mid;
   logic [32:0] sum_one;
   logic [32:0] sum_two;
   logic [31:0] sat_one;
   logic [31:0] sat_two;
   logic        job_out;

   always_comb begin
      word_new  = word_ff | ({24'b0, data_byte} << {pos_ff[1:0], 3'b000});
      rate_raw  = word_new[31:10];
      level_mid = level_ff + dssd_pkg::delta_of(data_byte[3:0]);
      sum_one   = {1'b0, count_ff} + 33'd1;
      sum_two   = {1'b0, count_ff} + 33'd2;
      sat_one   = sum_one[32] ? 32'hFFFF_FFFF : sum_one[31:0];
      sat_two   = sum_two[32] ? 32'hFFFF_FFFF : sum_two[31:0];
   end

   always_comb begin
      pos_in   = pos_ff;
      word_in  = word_ff;
      comp_in  = comp_ff;
      loop_in  = loop_ff;
      rate_in  = rate_ff;
      loff_in  = loff_ff;
      limit_in = limit_ff;
      level_in = level_ff;
      count_in = count_ff;
      job_out  = 1'b0;

      job.op         = dssd_pkg::OP_NONE;
      job.with_end   = final_byte;
      job.sample0    = 8'd0;
      job.sample1    = 8'd0;
      job.comp       = 1'b0;
      job.looped     = 1'b0;
      job.rate       = 22'd0;
      job.loop_start = 32'd0;
      job.total      = 32'd0;

      if (!pos_ff[4]) begin
         word_in = word_new;
         if (pos_ff[1:0] == 2'd3) begin
            unique case (pos_ff[3:2])
               2'd0: begin
                  comp_in = word_new[0];
                  loop_in = word_new[30];
               end
               2'd1: rate_in = (rate_raw == 22'd0) ? dssd_pkg::RateDefault : rate_raw;
               2'd2: loff_in = word_new;
               default: limit_in = word_new + 32'd1;
            endcase
            word_in = 32'd0;
         end
         pos_in = pos_ff + 5'd1;
         if (pos_ff[3:0] == 4'd15) begin
            job_out        = 1'b1;
            job.op         = dssd_pkg::OP_HEADER;
            job.comp       = comp_in;
            job.looped     = loop_in;
            job.rate       = rate_in;
            job.loop_start = loff_in;
            job.total      = limit_in;
         end else if (final_byte) begin
            job_out      = 1'b1;
            job.op       = dssd_pkg::OP_SHORT;
            job.with_end = 1'b0;
         end
      end else if (comp_ff) begin
         level_in    = level_mid + dssd_pkg::delta_of(data_byte[7:4]);
         count_in    = sat_two;
         job_out     = 1'b1;
         job.op      = dssd_pkg::OP_TWO_SAMPLES;
         job.sample0 = level_mid;
         job.sample1 = level_in;
         job.total   = sat_two;
      end else if (count_ff < limit_ff) begin
         count_in    = sat_one;
         job_out     = 1'b1;
         job.op      = dssd_pkg::OP_ONE_SAMPLE;
         job.sample0 = data_byte;
         job.total   = sat_one;
      end else begin
         job_out   = final_byte;
         job.total = count_ff;
      end

      if (final_byte) begin
         pos_in   = 5'd0;
         word_in  = 32'd0;
         comp_in  = 1'b0;
         loop_in  = 1'b0;
         rate_in  = 22'd0;
         loff_in  = 32'd0;
         limit_in = 32'd0;
         level_in = 8'd0;
         count_in = 32'd0;
      end
   end

   assign push = accept && job_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 5'd0;
         word_ff  <= 32'd0;
         comp_ff  <= 1'b0;
         loop_ff  <= 1'b0;
         rate_ff  <= 22'd0;
         loff_ff  <= 32'd0;
         limit_ff <= 32'd0;
         level_ff <= 8'd0;
         count_ff <= 32'd0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         word_ff  <= word_in;
         comp_ff  <= comp_in;
         loop_ff  <= loop_in;
         rate_ff  <= rate_in;
         loff_ff  <= loff_in;
         limit_ff <= limit_in;
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pos_ff <= 5'd16)
      else $error("header position out of range");
   assert property (@(posedge clock) disable iff (reset)
      accept && final_byte |=> pos_ff == 5'd0 && count_ff == 32'd0)
      else $error("state not cleared after final byte");
   assert property (@(posedge clock) disable iff (reset)
      !pos_ff[4] |-> count_ff == 32'd0 && level_ff == 8'd0)
      else $error("sample state moved during header");

endmodule

FILE: rtl/dssd_queue.sv
`timescale 1ns / 1ps
module dssd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dssd_pkg::job_type    push_job,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output dssd_pkg::job_type    head_job
);

   dssd_pkg::job_type slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head_job  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("pop from empty queue");

endmodule

FILE: rtl/dssd_back.sv
`timescale 1ns / 1ps
module dssd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  dssd_pkg::job_type    head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic signed [7:0]    rsp_pcm_value,
   output logic                 rsp_compressed_mode,
   output logic                 rsp_loop_enabled,
   output logic [21:0]          rsp_rate_hz,
   output logic [31:0]          rsp_loop_offset,
   output logic [31:0]          rsp_sample_total,
   output logic                 rsp_run_end
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  pcm_ff, pcm_in;
   logic        comp_ff, comp_in;
   logic        loop_ff, loop_in;
   logic [21:0] rate_ff, rate_in;
   logic [31:0] loff_ff, loff_in;
   logic [31:0] total_ff, total_in;
   logic        last_ff, last_in;

   logic [1:0] base_cnt;
   logic [1:0] res_cnt;
   logic       load;
   logic       is_last;

   always_comb begin
      unique case (head_job.op)
         dssd_pkg::OP_HEADER, dssd_pkg::OP_SHORT, dssd_pkg::OP_ONE_SAMPLE: base_cnt = 2'd1;
         dssd_pkg::OP_TWO_SAMPLES: base_cnt = 2'd2;
         default: base_cnt = 2'd0;
      endcase
      res_cnt = base_cnt + {1'b0, head_job.with_end};
      load    = not_empty && (!valid_ff || !rsp_stall);
      is_last = idx_ff == res_cnt - 2'd1;
      pop     = load && is_last;
   end

   always_comb begin
      kind_in  = dssd_pkg::KIND_END;
      pcm_in   = 8'd0;
      comp_in  = 1'b0;
      loop_in  = 1'b0;
      rate_in  = 22'd0;
      loff_in  = 32'd0;
      total_in = (head_job.op == dssd_pkg::OP_HEADER) ? 32'd0 : head_job.total;
      last_in  = is_last;
      if (idx_ff < base_cnt) begin
         unique case (head_job.op)
            dssd_pkg::OP_HEADER: begin
               kind_in  = dssd_pkg::KIND_HEADER;
               comp_in  = head_job.comp;
               loop_in  = head_job.looped;
               rate_in  = head_job.rate;
               loff_in  = head_job.loop_start;
               total_in = head_job.total;
            end
            dssd_pkg::OP_SHORT: begin
               kind_in  = dssd_pkg::KIND_SHORT;
               total_in = 32'd0;
            end
            default: begin
               kind_in  = dssd_pkg::KIND_SAMPLE;
               pcm_in   = (idx_ff == 2'd0) ? head_job.sample0 : head_job.sample1;
               total_in = 32'd0;
            end
         endcase
      end
      idx_in   = load ? (is_last ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         pcm_ff   <= pcm_in;
         comp_ff  <= comp_in;
         loop_ff  <= loop_in;
         rate_ff  <= rate_in;
         loff_ff  <= loff_in;
         total_ff <= total_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_pcm_value       = pcm_ff;
   assign rsp_compressed_mode = comp_ff;
   assign rsp_loop_enabled    = loop_ff;
   assign rsp_rate_hz         = rate_ff;
   assign rsp_loop_offset     = loff_ff;
   assign rsp_sample_total    = total_ff;
   assign rsp_run_end         = last_ff;

   assert property (@(posedge clock) disable iff (reset) idx_ff <= 2'd2)
      else $error("result index out of range");
   assert property (@(posedge clock) disable iff (reset) pop |-> load)
      else $error("job retired without a transfer");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == dssd_pkg::KIND_SHORT || kind_ff == dssd_pkg::KIND_END)
      |-> last_ff)
      else $error("terminal result without run end");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff != dssd_pkg::KIND_HEADER |-> !comp_ff && !loop_ff)
      else $error("header flags on non-header result");

endmodule

FILE: rtl/delta_sample_stream_decoder.sv
`timescale 1ns / 1ps
// Decodes a delta-coded sample file fed one byte per transfer. A byte is taken
// in every cycle while the two-entry job queue between the byte parser and the
// result sequencer has room. The result port issues one result per cycle, while
// rsp_stall is low, from a registered output stage, so the sustained rate is one
// byte per cycle in raw mode; in compressed mode each byte gives two samples and
// the result port bounds the byte rate. The job of a byte is written into the
// queue and then loaded into the output stage, from which its result transfers.
// The 16-byte header yields a header result, a final byte adds an end result,
// and a file that ends inside the header yields a single short-file result.
module delta_sample_stream_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_final_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [7:0]  rsp_pcm_value,
   output logic               rsp_compressed_mode,
   output logic               rsp_loop_enabled,
   output logic [21:0]        rsp_rate_hz,
   output logic [31:0]        rsp_loop_offset,
   output logic [31:0]        rsp_sample_total,
   output logic               rsp_run_end
);

   logic                    q_push;
   logic                    q_pop;
   logic                    q_full;
   logic                    q_not_empty;
   dssd_pkg::job_type       push_job;
   dssd_pkg::job_type       head_job;
   logic                    accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   dssd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .push       (q_push),
      .job        (push_job)
   );

   dssd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   dssd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .not_empty           (q_not_empty),
      .head_job            (head_job),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_pcm_value       (rsp_pcm_value),
      .rsp_compressed_mode (rsp_compressed_mode),
      .rsp_loop_enabled    (rsp_loop_enabled),
      .rsp_rate_hz         (rsp_rate_hz),
      .rsp_loop_offset     (rsp_loop_offset),
      .rsp_sample_total    (rsp_sample_total),
      .rsp_run_end         (rsp_run_end)
   );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int unsigned DirectedItems = 17;
   localparam int unsigned RandomItems = 125;
   localparam int unsigned QuietFrom = DirectedItems + RandomItems - 30;

   typedef struct packed {
      dssd_pkg::kind_type kind;
      logic [7:0]  pcm;
      logic        comp;
      logic        looped;
      logic [21:0] rate;
      logic [31:0] loop_start;
      logic [31:0] total;
      logic        run_end;
   } decoded_result_type;

   class sample_result_scoreboard;
      decoded_result_type awaited[$];
      int unsigned     mismatches;
      logic [4:0]      header_bytes;
      logic [31:0]     word_buf;
      logic            delta_coded;
      logic            looped;
      logic [21:0]     rate;
      logic [31:0]     loop_start;
      logic [31:0]     sample_limit;
      logic [7:0]      level;
      logic [31:0]     samples_out;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         header_bytes = '0;
         word_buf = '0;
         delta_coded = 1'b0;
         looped = 1'b0;
         rate = '0;
         loop_start = '0;
         sample_limit = '0;
         level = '0;
         samples_out = '0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function decoded_result_type blank(dssd_pkg::kind_type k);
         decoded_result_type r;
         r = '0;
         r.kind = k;
         return r;
      endfunction

      // squares upward for codes 0..7, squares downward for codes 8..15
      function logic [7:0] delta_step(logic [3:0] code);
         logic [7:0] mag;
         if (!code[3])
            return {4'b0, code} * {4'b0, code};
         mag = 8'd16 - {4'b0, code};
         return 8'd0 - mag * mag;
      endfunction

      function decoded_result_type count_sample(logic [7:0] v);
         decoded_result_type r;
         r = blank(dssd_pkg::KIND_SAMPLE);
         r.pcm = v;
         if (samples_out != 32'hFFFF_FFFF)
            samples_out = samples_out + 32'd1;
         return r;
      endfunction

      function void take_byte(logic [7:0] b, logic fin);
         decoded_result_type burst[$];
         decoded_result_type r;
         if (header_bytes < 5'd16) begin
            word_buf = word_buf | ({24'b0, b} << (8 * header_bytes[1:0]));
            if (header_bytes[1:0] == 2'd3) begin
               case (header_bytes[3:2])
                  2'd0: begin
                     delta_coded = word_buf[0];
                     looped = word_buf[30];
                  end
                  2'd1: rate = (word_buf[31:10] == 22'd0) ? dssd_pkg::RateDefault
                                                          : word_buf[31:10];
                  2'd2: loop_start = word_buf;
                  default: sample_limit = word_buf + 32'd1;
               endcase
               word_buf = '0;
            end
            header_bytes = header_bytes + 5'd1;
            if (header_bytes == 5'd16) begin
               r = blank(dssd_pkg::KIND_HEADER);
               r.comp = delta_coded;
               r.looped = looped;
               r.rate = rate;
               r.loop_start = loop_start;
               r.total = sample_limit;
               burst.push_back(r);
            end else if (fin) begin
               r = blank(dssd_pkg::KIND_SHORT);
               r.run_end = 1'b1;
               awaited.push_back(r);
               restart();
               return;
            end
         end else if (delta_coded) begin
            level = level + delta_step(b[3:0]);
            burst.push_back(count_sample(level));
            level = level + delta_step(b[7:4]);
            burst.push_back(count_sample(level));
         end else if (samples_out < sample_limit) begin
            burst.push_back(count_sample(b));
         end
         if (fin) begin
            r = blank(dssd_pkg::KIND_END);
            r.total = samples_out;
            burst.push_back(r);
            restart();
         end
         if (burst.size() != 0)
            burst[burst.size() - 1].run_end = 1'b1;
         foreach (burst[i])
            awaited.push_back(burst[i]);
      endfunction

      function void match_result(decoded_result_type got);
         decoded_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result kind %0d pcm %0d total %0d",
                        $time, got.kind, got.pcm, got.total);
            return;
         end
         want = awaited.pop_front();
         if (got.kind !== want.kind || got.pcm !== want.pcm || got.comp !== want.comp ||
             got.looped !== want.looped || got.rate !== want.rate ||
             got.loop_start !== want.loop_start || got.total !== want.total ||
             got.run_end !== want.run_end) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: expected kind %0d pcm %0d comp %0d loop %0d rate %0d off %0d tot %0d end %0d",
                        $time, want.kind, want.pcm, want.comp, want.looped, want.rate,
                        want.loop_start, want.total, want.run_end);
               $display("%0t: actual   kind %0d pcm %0d comp %0d loop %0d rate %0d off %0d tot %0d end %0d",
                        $time, got.kind, got.pcm, got.comp, got.looped, got.rate,
                        got.loop_start, got.total, got.run_end);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_data_byte;
   logic               req_final_byte;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [7:0]  rsp_pcm_value;
   logic               rsp_compressed_mode;
   logic               rsp_loop_enabled;
   logic [21:0]        rsp_rate_hz;
   logic [31:0]        rsp_loop_offset;
   logic [31:0]        rsp_sample_total;
   logic               rsp_run_end;

   sample_result_scoreboard board = new();
   int unsigned items_sent = 0;
   int unsigned stall_left = 0;

   delta_sample_stream_decoder u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_final_byte      (req_final_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_pcm_value       (rsp_pcm_value),
      .rsp_compressed_mode (rsp_compressed_mode),
      .rsp_loop_enabled    (rsp_loop_enabled),
      .rsp_rate_hz         (rsp_rate_hz),
      .rsp_loop_offset     (rsp_loop_offset),
      .rsp_sample_total    (rsp_sample_total),
      .rsp_run_end         (rsp_run_end)
   );

   always #1 clock = ~clock;

   // track both channels and pace the result side
   always @(posedge clock) begin
      decoded_result_type seen;
      if (!reset && req_valid && !req_stall)
         board.take_byte(req_data_byte, req_final_byte);
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind = dssd_pkg::kind_type'(rsp_kind);
         seen.pcm = rsp_pcm_value;
         seen.comp = rsp_compressed_mode;
         seen.looped = rsp_loop_enabled;
         seen.rate = rsp_rate_hz;
         seen.loop_start = rsp_loop_offset;
         seen.total = rsp_sample_total;
         seen.run_end = rsp_run_end;
         board.match_result(seen);
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end else if (items_sent < QuietFrom && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (items_sent < QuietFrom && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_word(input logic [31:0] w, input logic last);
      for (int i = 0; i < 4; i++)
         send_byte(w[8 * i +: 8], last && i == 3);
   endtask

   task automatic send_short_file(input int unsigned len);
      for (int unsigned i = 1; i <= len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len);
   endtask

   task automatic send_random_file();
      logic [31:0] flags;
      logic [31:0] rate_word;
      logic [31:0] count;
      int unsigned body;
      flags = $urandom();
      flags[0] = 1'($urandom_range(0, 1));
      flags[30] = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: rate_word = $urandom_range(0, 1023);
         1: rate_word = $urandom();
         2: rate_word = 32'hFFFF_FFFF;
         default: rate_word = $urandom_range(1024, 8000 * 1024);
      endcase
      case ($urandom_range(0, 4))
         3: count = 32'hFFFF_FFFF;
         4: count = $urandom();
         default: count = $urandom_range(0, 8);
      endcase
      body = $urandom_range(0, 12);
      send_word(flags, 1'b0);
      send_word(rate_word, 1'b0);
      send_word($urandom(), 1'b0);
      send_word(count, body == 0);
      for (int unsigned i = 1; i <= body; i++)
         send_byte(8'($urandom_range(0, 255)), i == body);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_final_byte <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // file cut off at its first byte
      send_byte(8'hFF, 1'b1);
      // all-ones header whose last byte closes the file
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);

      while (items_sent < DirectedItems + RandomItems) begin
         if ($urandom_range(0, 5) == 0)
            send_short_file($urandom_range(1, 15));
         else
            send_random_file();
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("** delta_sample_stream_decoder: PASSED **");
      else
         $display("** delta_sample_stream_decoder: FAILED **");
      $finish;
   end

   initial begin
      #400000;
      $display("** delta_sample_stream_decoder: FAILED **");
      $finish;
   end

endmodule

FILE: files.f
rtl/dssd_pkg.sv
rtl/dssd_front.sv
rtl/dssd_queue.sv
rtl/dssd_back.sv
rtl/delta_sample_stream_decoder.sv
verif/tb.sv
